### rtl/core/assert_macros.svh
// Assertion macros used by the top level RTL file of the quadratic root solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT(lbl, prop, msg) `QRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define QRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define QRS_ASSERT(lbl, prop, msg)
`endif
`endif

### rtl/core/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
package qrs_pkg;

  localparam int COEF_WIDTH_DEF   = 16;
  localparam int RESULT_WIDTH_DEF = 32;
  localparam int FRAC_BITS        = 16;

  typedef enum logic [1:0] {
    KIND_LINEAR   = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_REPEATED = 2'd2,
    KIND_COMPLEX  = 2'd3
  } kind_e;

endpackage

### rtl/core/qrs_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
module qrs_sqrt import qrs_pkg::*; #(
  parameter int MAG_W  = 2 * COEF_WIDTH_DEF + 2,
  parameter int SIDE_W = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [MAG_W-1:0]                       mag_i,
  input  logic [SIDE_W-1:0]                      side_i,
  output logic                                   valid_o,
  output logic [(MAG_W+2*FRAC_BITS)/2-1:0]       root_o,
  output logic [SIDE_W-1:0]                      side_o
);

  localparam int XW   = MAG_W + 2 * FRAC_BITS;
  localparam int SQ_W = XW / 2;
  localparam int RW   = SQ_W + 3;

  logic [XW-1:0]     x_q    [SQ_W];
  logic [RW-1:0]     r_q    [SQ_W];
  logic [SQ_W-1:0]   q_q    [SQ_W];
  logic [SIDE_W-1:0] side_q [SQ_W];
  logic              v_q    [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [XW-1:0]     x_in;
    logic [RW-1:0]     r_in;
    logic [RW-1:0]     r_sh;
    logic [RW-1:0]     t;
    logic [SQ_W-1:0]   q_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (k == 0) begin : g_first
      assign x_in = {mag_i, {(2 * FRAC_BITS){1'b0}}};
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
      assign q_in = q_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign r_sh = {r_in[RW-3:0], x_in[XW-1 -: 2]};
    assign t    = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in << 2;
        side_q[k] <= s_in;
        if (r_sh >= t) begin
          r_q[k] <= r_sh - t;
          q_q[k] <= {q_in[SQ_W-2:0], 1'b1};
        end else begin
          r_q[k] <= r_sh;
          q_q[k] <= {q_in[SQ_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[SQ_W-1];
  assign root_o  = q_q[SQ_W-1];
  assign side_o  = side_q[SQ_W-1];

endmodule

### rtl/core/qrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module qrs_div import qrs_pkg::*; #(
  parameter int NUM_W  = COEF_WIDTH_DEF + FRAC_BITS + 4,
  parameter int DEN_W  = COEF_WIDTH_DEF + 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  n_q    [NUM_W];
  logic [DEN_W-1:0]  d_q    [NUM_W];
  logic [DEN_W-1:0]  r_q    [NUM_W];
  logic [NUM_W-1:0]  q_q    [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];
  logic              v_q    [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]  n_in;
    logic [DEN_W-1:0]  d_in;
    logic [DEN_W-1:0]  r_in;
    logic [NUM_W-1:0]  q_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [DEN_W:0]    rr;
    logic [DEN_W:0]    diff;

    if (k == 0) begin : g_first
      assign n_in = num_i;
      assign d_in = den_i;
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign d_in = d_q[k-1];
      assign r_in = r_q[k-1];
      assign q_in = q_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign rr   = {r_in, n_in[NUM_W-1]};
    assign diff = rr - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in << 1;
        d_q[k]    <= d_in;
        side_q[k] <= s_in;
        if (rr >= {1'b0, d_in}) begin
          r_q[k] <= diff[DEN_W-1:0];
          q_q[k] <= {q_in[NUM_W-2:0], 1'b1};
        end else begin
          r_q[k] <= rr[DEN_W-1:0];
          q_q[k] <= {q_in[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quot_o  = q_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

### rtl/core/quadratic_root_solver.sv
// Quadratic root solver top level: a fully pipelined quadratic formula evaluator.
// One coefficient request is accepted every cycle and one result leaves every cycle while
// the output is not stalled. The pipeline is made of the input register that loads at the
// accepting edge, the square root pipeline (COEF_WIDTH + 17 stages), the two parallel
// divider pipelines (COEF_WIDTH + 20 stages) and five stages of multiply, discriminant,
// numerator, rounding and output registers. When the output is not taken, the whole
// pipeline holds and input ready drops.
`include "assert_macros.svh"

module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [COEF_WIDTH-1:0]   coef_square_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_linear_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_const_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     root_kind_o,
  output logic signed [RESULT_WIDTH-1:0] value_one_o,
  output logic signed [RESULT_WIDTH-1:0] value_two_o,
  output logic                           saturated_o
);

  localparam int W      = COEF_WIDTH;
  localparam int R      = RESULT_WIDTH;
  localparam int DISC_W = 2 * W + 3;
  localparam int MAG_W  = 2 * W + 2;
  localparam int SQ_W   = (MAG_W + 2 * FRAC_BITS) / 2;
  localparam int BASE_W = W + 1 + FRAC_BITS;
  localparam int NUMS_W = BASE_W + 2;
  localparam int NUM_W  = NUMS_W + 1;
  localparam int DEN_W  = W + 2;
  localparam int EXT_W  = (NUM_W > R ? NUM_W : R) + 1;
  localparam int SQS_W  = 2 * W + 1;
  localparam int DVS_W  = 4;
  localparam logic [R-1:0] MAX_V = {1'b0, {(R - 1){1'b1}}};
  localparam logic [R-1:0] MIN_V = {1'b1, {(R - 1){1'b0}}};

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic                v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [W-1:0] a0_q, b0_q, c0_q, a1_q, b1_q;
  logic signed [2*W-1:0] bb1_q, ac1_q;

  logic signed [DISC_W-1:0] disc;
  logic [DISC_W-1:0]        disc_abs;
  logic [MAG_W-1:0]         mag2_q;
  logic [SQS_W-1:0]         side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  assign disc     = {{3{bb1_q[2*W-1]}}, bb1_q} - ({{3{ac1_q[2*W-1]}}, ac1_q} <<< 2);
  assign disc_abs = disc[DISC_W-1] ? -disc : disc;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q    <= coef_square_i;
      b0_q    <= coef_linear_i;
      c0_q    <= coef_const_i;
      a1_q    <= a0_q;
      b1_q    <= b0_q;
      bb1_q   <= b0_q * b0_q;
      ac1_q   <= a0_q * c0_q;
      mag2_q  <= disc_abs[MAG_W-1:0];
      side2_q <= {a1_q, b1_q, disc[DISC_W-1]};
    end
  end

  logic             sq_valid;
  logic [SQ_W-1:0]  sq_root;
  logic [SQS_W-1:0] sq_side;

  qrs_sqrt #(
    .MAG_W  (MAG_W),
    .SIDE_W (SQS_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .mag_i   (mag2_q),
    .side_i  (side2_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  logic signed [W-1:0]      sa, sb;
  logic                     sdneg;
  logic signed [W:0]        negb;
  logic signed [BASE_W-1:0] base;
  logic signed [NUMS_W-1:0] basex, sx;
  logic [W:0]               amag;
  kind_e                    kind;

  assign sa    = sq_side[SQS_W-1 -: W];
  assign sb    = sq_side[W:1];
  assign sdneg = sq_side[0];
  assign negb  = -{sb[W-1], sb};
  assign base  = {negb, {FRAC_BITS{1'b0}}};
  assign basex = {{2{base[BASE_W-1]}}, base};
  assign sx    = {2'b00, sq_root};
  assign amag  = sa[W-1] ? -{sa[W-1], sa} : {sa[W-1], sa};

  always_comb begin
    if (sa == '0) begin
      kind = KIND_LINEAR;
    end else if (sdneg) begin
      kind = KIND_COMPLEX;
    end else if (sq_root == '0) begin
      kind = KIND_REPEATED;
    end else begin
      kind = KIND_DISTINCT;
    end
  end

  logic signed [NUMS_W-1:0] n1_q, n2_q;
  logic [W:0]               amag3_q;
  logic                     aneg3_q;
  kind_e                    kind3_q;

  logic [NUMS_W-1:0] m1, m2;
  logic [NUMS_W-2:0] un1, un2;
  logic [NUM_W-1:0]  num1_q, num2_q;
  logic [DEN_W-1:0]  den4_q;
  logic [DVS_W-1:0]  side4_q;

  assign m1  = -n1_q;
  assign m2  = -n2_q;
  assign un1 = n1_q[NUMS_W-1] ? m1[NUMS_W-2:0] : n1_q[NUMS_W-2:0];
  assign un2 = n2_q[NUMS_W-1] ? m2[NUMS_W-2:0] : n2_q[NUMS_W-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v3_q <= sq_valid;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q    <= sdneg ? basex : basex + sx;
      n2_q    <= sdneg ? sx : basex - sx;
      amag3_q <= amag;
      aneg3_q <= sa[W-1];
      kind3_q <= kind;
      num1_q  <= NUM_W'({un1, 1'b0}) + NUM_W'({amag3_q, 1'b0});
      num2_q  <= NUM_W'({un2, 1'b0}) + NUM_W'({amag3_q, 1'b0});
      den4_q  <= DEN_W'({amag3_q, 2'b00});
      side4_q <= {kind3_q, n1_q[NUMS_W-1] ^ aneg3_q, n2_q[NUMS_W-1] ^ aneg3_q};
    end
  end

  logic             dv_valid;
  logic [NUM_W-1:0] q1, q2;
  logic [DVS_W-1:0] dv_side;

  qrs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .SIDE_W (DVS_W)
  ) u_div_one (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num1_q),
    .den_i   (den4_q),
    .side_i  (side4_q),
    .valid_o (dv_valid),
    .quot_o  (q1),
    .side_o  (dv_side)
  );

  qrs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .SIDE_W (DVS_W)
  ) u_div_two (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num2_q),
    .den_i   (den4_q),
    .side_i  (side4_q),
    .valid_o (),
    .quot_o  (q2),
    .side_o  ()
  );

  function automatic logic [R:0] clip(input logic [NUM_W-1:0] q, input logic neg);
    logic [EXT_W-1:0] qe;
    logic [EXT_W-1:0] lim;
    logic [R-1:0]     v;
    logic             s;
    qe = EXT_W'(q);
    lim = EXT_W'(1) << (R - 1);
    s = 1'b0;
    if (neg && q != '0) begin
      if (qe > lim) begin
        s = 1'b1;
        v = MIN_V;
      end else begin
        v = R'(EXT_W'(0) - qe);
      end
    end else if (qe > lim - EXT_W'(1)) begin
      s = 1'b1;
      v = MAX_V;
    end else begin
      v = R'(qe);
    end
    return {s, v};
  endfunction

  kind_e      dkind;
  logic [R:0] c1, c2;
  logic       lin;

  assign dkind = kind_e'(dv_side[3:2]);
  assign lin   = dkind == KIND_LINEAR;
  assign c1    = clip(q1, dv_side[1]);
  assign c2    = clip(q2, dv_side[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_kind_o <= dkind;
      value_one_o <= lin ? '0 : c1[R-1:0];
      value_two_o <= lin ? '0 : c2[R-1:0];
      saturated_o <= !lin && (c1[R] || c2[R]);
    end
  end

  `QRS_ASSERT(a_linear_zero, out_valid_o && root_kind_o == KIND_LINEAR |-> value_one_o == '0 && value_two_o == '0 && !saturated_o, "Linear result carries nonzero values.")
  `QRS_ASSERT(a_repeated_equal, out_valid_o && root_kind_o == KIND_REPEATED |-> value_one_o == value_two_o, "Repeated root values differ.")
  `QRS_ASSERT(a_sat_extreme, out_valid_o && saturated_o |-> value_one_o == MAX_V || value_one_o == MIN_V || value_two_o == MAX_V || value_two_o == MIN_V, "Saturation flag without a clipped value.")
  `QRS_ASSERT_CLK(a_stall_ready, clk_i, rst_ni, out_valid_o && !out_ready_i |-> !in_ready_o, "Request accepted while the pipeline is stalled.")

endmodule
